@@ hw/rtl/radix_string_to_int64_unit_macros.svh @@
// Assertion macros for the radix string to int64 unit
`ifndef RADIX_STRING_TO_INT64_UNIT_MACROS_SVH
`define RADIX_STRING_TO_INT64_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on the rising clock, off during reset
`define RSTI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on the rising clock, off during reset
`define RSTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSTI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define RSTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hw/rtl/rsti_pkg.sv @@
// Shared types and constants for the radix string to int64 unit
`default_nettype none

package rsti_pkg;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Base limits and reset value
  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [5:0] RADIX_RESET = 6'd10;
  localparam logic [5:0] NO_DIGIT    = 6'd36;

  // Saturation values
  localparam logic [63:0] NUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NUM_MIN = 64'h8000_0000_0000_0000;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // Result offset width and queue depth
  localparam int END_OFFSET_W = 16;
  localparam int Q_DEPTH      = 2;

  typedef struct packed {
    logic       start_req;
    logic [7:0] ch;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0]        number;
    logic [1:0]                status;
    logic [END_OFFSET_W-1:0]   end_offset;
  } out_word_t;

  // Classified character as it travels from front to back
  typedef struct packed {
    logic       start;
    logic       blank;
    logic       minus;
    logic       digit_ok;
    logic       base_bad;
    logic [5:0] digit;
    logic [5:0] radix;
  } cls_word_t;

endpackage

`default_nettype wire

@@ hw/rtl/rsti_front.sv @@
// Front end: radix register and character classification
`default_nettype none

module rsti_front
  import rsti_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire logic [5:0] cfg_wdata,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_word,
  output logic           push_valid,
  input  wire logic      push_ready,
  output cls_word_t      push_word
);

  logic [5:0] radix_r;
  logic [5:0] digit;

  // Hold the configured base
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  // Map the character to its digit value
  always_comb begin
    case (in_word.ch) inside
      [8'h30:8'h39]: digit = 6'(in_word.ch - 8'h30);
      [8'h41:8'h5A]: digit = 6'(in_word.ch - 8'h41 + 8'd10);
      [8'h61:8'h7A]: digit = 6'(in_word.ch - 8'h61 + 8'd10);
      default:       digit = NO_DIGIT;
    endcase
  end

  // Build the classified word
  always_comb begin
    push_word.start    = in_word.start_req;
    push_word.blank    = (in_word.ch == CH_SPACE) || (in_word.ch == CH_TAB);
    push_word.minus    = (in_word.ch == CH_MINUS);
    push_word.digit_ok = (digit < radix_r);
    push_word.base_bad = (radix_r < RADIX_MIN) || (radix_r > RADIX_MAX);
    push_word.digit    = digit;
    push_word.radix    = radix_r;
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

`default_nettype wire

@@ hw/rtl/rsti_queue.sv @@
// Short queue between front and back ends
`default_nettype none

module rsti_queue
  import rsti_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire cls_word_t push_word,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output cls_word_t      pop_word
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cls_word_t        mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_word   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rsti_back.sv @@
// Back end: parse state, digit accumulate with range check, result register
`default_nettype none

module rsti_back
  import rsti_pkg::*;
#(
  parameter int OFFSET_WIDTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      pop_valid,
  output logic           pop_ready,
  input  wire cls_word_t pop_word,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word
);

  localparam int EXT_W  = (OFFSET_WIDTH > END_OFFSET_W) ? OFFSET_WIDTH : END_OFFSET_W;
  localparam int PROD_W = 70;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LEAD = 4'b0010,
    PH_DIGS = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  phase_t                  phase_r, phase_nxt, phase_cur;
  logic                    negative_r, negative_nxt, negative_cur;
  logic [63:0]             accum_r, accum_nxt, accum_cur;
  logic                    seen_r, seen_nxt, seen_cur;
  logic                    ovf_r, ovf_nxt, ovf_cur;
  logic [OFFSET_WIDTH-1:0] pos_r, pos_nxt, pos_cur;
  logic                    out_valid_r;
  out_word_t               out_word_r;
  logic                    fire, emit;
  logic [1:0]              emit_status;
  logic [PROD_W-1:0]       prod;
  logic [63:0]             limit;
  logic [EXT_W-1:0]        pos_ext;
  logic [END_OFFSET_W-1:0] off_sat;
  out_word_t               res;

  assign fire      = pop_valid && (!out_valid_r || out_ready);
  assign pop_ready = !out_valid_r || out_ready;

  // Start of string restarts the parse state
  always_comb begin
    phase_cur    = pop_word.start ? PH_LEAD : phase_r;
    negative_cur = pop_word.start ? 1'b0 : negative_r;
    accum_cur    = pop_word.start ? '0 : accum_r;
    seen_cur     = pop_word.start ? 1'b0 : seen_r;
    ovf_cur      = pop_word.start ? 1'b0 : ovf_r;
    pos_cur      = pop_word.start ? '0 : pos_r;
  end

  // Multiply-accumulate and compare against the limit for the sign
  assign prod  = PROD_W'(accum_cur) * PROD_W'(pop_word.radix) + PROD_W'(pop_word.digit);
  assign limit = negative_cur ? NUM_MIN : NUM_MAX;

  // Step the parse for one character
  always_comb begin
    phase_nxt    = phase_cur;
    negative_nxt = negative_cur;
    accum_nxt    = accum_cur;
    seen_nxt     = seen_cur;
    ovf_nxt      = ovf_cur;
    pos_nxt      = pos_cur;
    emit         = 1'b0;
    emit_status  = ST_OK;
    if ((phase_cur == PH_LEAD) || (phase_cur == PH_DIGS)) begin
      if (pop_word.base_bad) begin
        emit         = 1'b1;
        emit_status  = ST_INVALID;
        negative_nxt = 1'b0;
        accum_nxt    = '0;
        phase_nxt    = PH_DONE;
      end else if ((phase_cur == PH_LEAD) && pop_word.blank) begin
        phase_nxt = PH_LEAD;
      end else if ((phase_cur == PH_LEAD) && pop_word.minus) begin
        negative_nxt = 1'b1;
        phase_nxt    = PH_DIGS;
      end else if (pop_word.digit_ok) begin
        seen_nxt  = 1'b1;
        phase_nxt = PH_DIGS;
        if (!ovf_cur) begin
          if (prod > PROD_W'(limit)) begin
            ovf_nxt = 1'b1;
          end else begin
            accum_nxt = prod[63:0];
          end
        end
      end else begin
        emit      = 1'b1;
        phase_nxt = PH_DONE;
        if (!seen_cur) begin
          emit_status = ST_INVALID;
        end else if (ovf_cur) begin
          emit_status = ST_RANGE;
        end else begin
          emit_status = ST_OK;
        end
      end
      if (pos_cur != '1) begin
        pos_nxt = pos_cur + 1'b1;
      end
    end
  end

  // Form the result word
  assign pos_ext = EXT_W'(pos_cur);
  assign off_sat = (pos_ext > EXT_W'({END_OFFSET_W{1'b1}})) ? '1 : pos_ext[END_OFFSET_W-1:0];

  always_comb begin
    res.status = emit_status;
    case (emit_status)
      ST_OK: begin
        res.number     = negative_cur ? -accum_cur : accum_cur;
        res.end_offset = off_sat;
      end
      ST_RANGE: begin
        res.number     = negative_cur ? NUM_MIN : NUM_MAX;
        res.end_offset = off_sat;
      end
      default: begin
        res.number     = '0;
        res.end_offset = '0;
      end
    endcase
  end

  // Commit parse state on each consumed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      negative_r <= 1'b0;
      accum_r    <= '0;
      seen_r     <= 1'b0;
      ovf_r      <= 1'b0;
      pos_r      <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      negative_r <= negative_nxt;
      accum_r    <= accum_nxt;
      seen_r     <= seen_nxt;
      ovf_r      <= ovf_nxt;
      pos_r      <= pos_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

@@ hw/rtl/radix_string_to_int64_unit.sv @@
// Top level of the streaming radix string to int64 parser
//
//   channel   dir  handshake            payload
//   in_       in   in_valid/in_ready    in_word_t  {start_req, ch}
//   out_      out  out_valid/out_ready  out_word_t {number, status, end_offset}
//   cfg_      in   cfg_we               cfg_wdata  radix, 6 bits
//
// One character word is taken per cycle while the queue has room; the back
// end does one 64x6 multiply-accumulate and limit compare per cycle, so
// throughput is one word a cycle while results are taken. A terminating
// character is registered in the queue, then its result in the back end.
// A two-entry queue separates classification from parsing; the back end
// stalls only while a result sits in the output register and is not taken.
// Synchronous active-low reset clears control state; radix resets to 10.
`default_nettype none

`include "radix_string_to_int64_unit_macros.svh"

module radix_string_to_int64_unit
  import rsti_pkg::*;
#(
  parameter int OFFSET_WIDTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [5:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_word_t   in_word,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_word_t       out_word
);

  logic      push_valid, push_ready;
  cls_word_t push_word;
  logic      pop_valid, pop_ready;
  cls_word_t pop_word;

  // Classify incoming characters
  rsti_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word)
  );

  // Decouple front and back
  rsti_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word)
  );

  // Parse and emit results
  rsti_back #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_word  (pop_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // Invalid results carry zero value and zero offset
  `RSTI_ASSERT_IMPL(a_invalid_zero, clk, rst_n,
                    out_valid && (out_word.status == ST_INVALID),
                    (out_word.number == 64'sd0) && (out_word.end_offset == '0),
                    "invalid result not zeroed")
  // Range results are saturated to one of the two extremes
  `RSTI_ASSERT_IMPL(a_range_sat, clk, rst_n,
                    out_valid && (out_word.status == ST_RANGE),
                    (out_word.number == NUM_MAX) || (out_word.number == NUM_MIN),
                    "range result not saturated")
  // A number with digits ends past its first character
  `RSTI_ASSERT_IMPL(a_offset_nonzero, clk, rst_n,
                    out_valid && (out_word.status != ST_INVALID),
                    out_word.end_offset != '0,
                    "zero offset on parsed number")

endmodule

`default_nettype wire
